// ----- sv/sha1_hash_assert.svh -----
// ----------------------------------------------------------------------------
// sha1_hash_assert.svh
// Assertion macros for the SHA-1 engine; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ASSERT_SVH
`define SHA1_HASH_ASSERT_SVH

`ifndef SYNTHESIS
// concurrent assertion on an explicit clock and reset
`define SHA_ASSERT_CLK(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) prop) else $error(msg);
// concurrent assertion on the module's clk and rst
`define SHA_ASSERT(lbl, prop, msg) `SHA_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define SHA_ASSERT_CLK(lbl, clk_i, rst_i, prop, msg)
`define SHA_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- sv/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Types and constants shared by the SHA-1 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

  localparam int BLK_BYTES = 64;
  localparam int BLK_BITS  = 8 * BLK_BYTES;
  localparam int ROUNDS    = 80;
  localparam int LEN_POS   = 56;

  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;

  // five working / chaining words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_work_t;

  localparam sha_work_t SHA_IV = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  // block buffer control
  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       word_en;
  } sha_sched_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } sha_fsm_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } sha_pad_t;

endpackage

// ----- sv/sha_if.sv -----
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready stream interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha1_hash.sv -----
// ----------------------------------------------------------------------------
// sha1_hash
// Streaming SHA-1 engine: byte input, padding, one round per cycle, digest out.
// ----------------------------------------------------------------------------
//   channel     dir  payload                                  transfer when
//   in_stream   in   data_byte[7:0] has_byte end_of_message   valid && ready
//   out_stream  out  digest_word[31:0] word_index[2:0]        valid && ready
//                    last_word
//
// The byte item that fills a block starts compression: 80 rounds in the shared
// round unit, then the chaining add.
// end_of_message starts padding, one padding byte per cycle through the block
// shift line, with a compression after each of the one or two padded blocks,
// then five digest transfers, one per cycle when out_stream is ready.
// Synchronous reset loads the initial chaining words; no clearing pass.
// in_stream.ready is low from padding until the last digest transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_hash (
  input logic clk,
  input logic rst,
  sha_in_if.sink    in_stream,
  sha_out_if.source out_stream
);
  import sha_pkg::*;

  `include "sha1_hash_assert.svh"

  localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
  localparam logic [5:0] FILL_LAST  = 6'(BLK_BYTES - 1);
  localparam logic [5:0] FILL_PRE   = 6'(LEN_POS - 1);

  sha_fsm_t       state, state_next;
  sha_pad_t       pad_phase;
  logic [5:0]     fill;            // bytes now in the block buffer
  logic [63:0]    bit_count;       // message length, wraps
  logic           padding;         // message closed, padding under way
  logic           final_blk;       // current block carries the length field
  logic [6:0]     round;
  logic [2:0]     widx;
  sha_work_t      chain;
  sha_work_t      work;
  sha_work_t      work_next;
  sha_sched_ctl_t ctl;
  logic [31:0]    w_cur;
  logic [7:0]     len_byte;
  logic           in_xfer;
  logic           out_xfer;
  logic           start_comp;

  assign in_xfer  = in_stream.valid && in_stream.ready;
  assign out_xfer = out_stream.valid && out_stream.ready;

  // length bytes go out big-endian: fill 56 takes bits 63..56
  assign len_byte = 8'(bit_count >> {3'd7 - fill[2:0], 3'b000});

  sha_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  sha_round u_round (
    .cur   (work),
    .w     (w_cur),
    .round (round),
    .nxt   (work_next)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_stream.ready  = 1'b0;
    out_stream.valid = 1'b0;
    ctl.byte_en      = 1'b0;
    ctl.byte_val     = in_stream.data_byte;
    ctl.word_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stream.ready = 1'b1;
        if (in_stream.valid) begin
          ctl.byte_en = in_stream.has_byte;
          if (in_stream.has_byte && fill == FILL_LAST) begin
            state_next = S_COMP;
          end else if (in_stream.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctl.byte_en = 1'b1;
        unique case (pad_phase)
          PAD_MARK: ctl.byte_val = 8'h80;
          PAD_ZERO: ctl.byte_val = 8'h00;
          PAD_LEN:  ctl.byte_val = len_byte;
          default:  ctl.byte_val = 8'h00;
        endcase
        if (fill == FILL_LAST) begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        ctl.word_en = 1'b1;
        if (round == ROUND_LAST) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        priority if (final_blk) begin
          state_next = S_OUT;
        end else if (padding) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        out_stream.valid = 1'b1;
        if (out_stream.ready && widx == 3'd4) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign start_comp = ctl.byte_en && fill == FILL_LAST;

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bit_count <= '0;
      padding   <= 1'b0;
      final_blk <= 1'b0;
      pad_phase <= PAD_MARK;
      round     <= '0;
      widx      <= '0;
      chain     <= SHA_IV;
    end else begin
      if (ctl.byte_en) begin
        fill <= fill + 6'd1;
      end
      if (in_xfer && in_stream.has_byte) begin
        bit_count <= bit_count + 64'd8;
      end
      if (in_xfer && in_stream.end_of_message) begin
        padding   <= 1'b1;
        pad_phase <= PAD_MARK;
      end

      // zeros run until the length field starts at byte 56
      if (state == S_PAD) begin
        unique case (pad_phase)
          PAD_MARK: pad_phase <= (fill == FILL_PRE) ? PAD_LEN : PAD_ZERO;
          PAD_ZERO: begin
            if (fill == FILL_PRE) begin
              pad_phase <= PAD_LEN;
            end
          end
          PAD_LEN: begin
            if (fill == FILL_LAST) begin
              final_blk <= 1'b1;
            end
          end
          default: pad_phase <= PAD_MARK;
        endcase
      end

      if (start_comp) begin
        round <= '0;
      end else if (state == S_COMP) begin
        round <= round + 7'd1;
      end

      if (state == S_ADD) begin
        chain.a <= chain.a + work.a;
        chain.b <= chain.b + work.b;
        chain.c <= chain.c + work.c;
        chain.d <= chain.d + work.d;
        chain.e <= chain.e + work.e;
      end

      // last digest word: back to the initial state
      if (out_xfer) begin
        if (widx == 3'd4) begin
          widx      <= '0;
          chain     <= SHA_IV;
          bit_count <= '0;
          padding   <= 1'b0;
          final_blk <= 1'b0;
        end else begin
          widx <= widx + 3'd1;
        end
      end
    end
  end

  // working words: loaded at block start, one round per cycle
  always_ff @(posedge clk) begin
    if (start_comp) begin
      work <= chain;
    end else if (state == S_COMP) begin
      work <= work_next;
    end
  end

  // --------------------------------------------------------------------------
  // digest output
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (widx)
      3'd0:    out_stream.digest_word = chain.a;
      3'd1:    out_stream.digest_word = chain.b;
      3'd2:    out_stream.digest_word = chain.c;
      3'd3:    out_stream.digest_word = chain.d;
      default: out_stream.digest_word = chain.e;
    endcase
  end

  assign out_stream.word_index = widx;
  assign out_stream.last_word  = (widx == 3'd4);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SHA_ASSERT(a_no_overlap, !(in_stream.ready && out_stream.valid), "input taken during digest")
  `SHA_ASSERT(a_comp_fill, (state == S_COMP) |-> (fill == 6'd0), "compression on partial block")
  `SHA_ASSERT(a_out_index, out_stream.valid |-> (widx <= 3'd4), "digest index out of range")
  `SHA_ASSERT(a_reload, (out_xfer && out_stream.last_word) |=> (in_stream.ready && bit_count == 64'd0 && fill == 6'd0), "state not reloaded after digest")

endmodule

// ----- sv/sha_sched.sv -----
// ----------------------------------------------------------------------------
// sha_sched
// 64-byte block buffer and message schedule as one 16-word shift line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_sched (
  input  logic                    clk,
  input  sha_pkg::sha_sched_ctl_t ctl,
  output logic [31:0]             w_cur
);
  import sha_pkg::*;

  logic [BLK_BITS-1:0] blk;
  logic [31:0]         w_mix;
  logic [31:0]         w_new;

  // word j of the window sits at blk[BLK_BITS-1-32*j -: 32]
  assign w_cur = blk[BLK_BITS-1 -: 32];
  assign w_mix = blk[BLK_BITS-1-32*13 -: 32] ^ blk[BLK_BITS-1-32*8 -: 32] ^
                 blk[BLK_BITS-1-32*2 -: 32] ^ blk[BLK_BITS-1 -: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // bytes enter at the low end, so the first byte ends up in the top bits
  always_ff @(posedge clk) begin
    if (ctl.byte_en) begin
      blk <= {blk[BLK_BITS-9:0], ctl.byte_val};
    end else if (ctl.word_en) begin
      blk <= {blk[BLK_BITS-33:0], w_new};
    end
  end

endmodule

// ----- sv/sha_round.sv -----
// ----------------------------------------------------------------------------
// sha_round
// One SHA-1 round: round function, constant select and the five-term add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_round (
  input  sha_pkg::sha_work_t cur,
  input  logic [31:0]        w,
  input  logic [6:0]         round,
  output sha_pkg::sha_work_t nxt
);
  import sha_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    priority if (round < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = SHA_K0;
    end else if (round < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = SHA_K1;
    end else if (round < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = SHA_K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = SHA_K3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

  assign nxt = '{
    a: t,
    b: cur.a,
    c: {cur.b[1:0], cur.b[31:2]},
    d: cur.c,
    e: cur.d
  };

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming SHA-1 engine. Message bytes go in over
// the input stream. A SHA-1 model inside the bench, with its own padding and
// its own chaining state, works out the five digest words that each message
// should produce. Every digest word transfer is checked field by field against
// the oldest pending word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sha_pkg::*;

  // cycles with no transfer on either stream before the run is declared hung;
  // the worst case spans two pad blocks, their compressions and the sink hold-off
  localparam int STALL_LIMIT   = 3000;
  // quiet time after all items are taken and the last digest word is seen
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 300;  // one long sink hold-off
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_ITEMS  = 100;
  localparam int RANDOM_MSGS   = 3;

  // one input transfer; drain makes the driver wait for all pending digests
  // before it offers this item
  typedef struct {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    bit         drain;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_entry_t;

  logic clk;
  logic rst;

  sha_in_if  in_stream();
  sha_out_if out_stream();

  sha1_hash u_top (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_stream),
    .out_stream (out_stream)
  );

  msg_item_t     item_queue[$];   // stimulus not yet offered
  digest_entry_t digest_due[$];   // digest words predicted, not yet seen
  msg_item_t     live_item;       // item on the input stream right now

  int items_total;
  int items_taken;      // input transfers (NBA, read by both sides)
  int words_expected;   // digest words predicted so far (driver only)
  int words_seen;       // digest word transfers (NBA)
  int real_items;       // stimulus items the engine acts on
  int mismatches;
  int quiet_cycles;
  int hold_left;
  bit hold_done;

  // SHA-1 state of the bench's own model
  logic [31:0] chain [5];
  logic [63:0] msg_bits;
  logic [7:0]  block_buf [64];
  logic [5:0]  block_fill;

  // --------------------------------------------------------------------------
  // SHA-1 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // 80 rounds over block_buf, added into the chaining words
  function automatic void run_rounds();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < ROUNDS; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = SHA_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = SHA_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA_K2;
      end else begin
        f = b ^ c ^ d;
        k = SHA_K3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // block fill wraps at 64; a wrap means the block is full
  function automatic void take_byte(input logic [7:0] v);
    block_buf[block_fill] = v;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0)
      run_rounds();
  endfunction

  function automatic void reload_chain();
    chain[0]   = SHA_IV.a;
    chain[1]   = SHA_IV.b;
    chain[2]   = SHA_IV.c;
    chain[3]   = SHA_IV.d;
    chain[4]   = SHA_IV.e;
    msg_bits   = '0;
    block_fill = '0;
  endfunction

  // apply one accepted item; on end of message pad, finish, queue the digest
  function automatic void hash_item(input msg_item_t it);
    logic [63:0]   len;
    digest_entry_t dw;
    if (it.has_byte) begin
      take_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.end_of_message) begin
      len = msg_bits;
      take_byte(8'h80);
      while (block_fill != LEN_POS)
        take_byte(8'h00);
      for (int i = 0; i < 8; i++)
        take_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        dw.digest_word = chain[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (i == 4);
        digest_due.push_back(dw);
      end
      words_expected += 5;
      reload_chain();
    end
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(input logic [7:0] data, input logic has,
                                   input logic eom, input bit drain);
    msg_item_t it;
    it.data_byte      = data;
    it.has_byte       = has;
    it.end_of_message = eom;
    it.drain          = drain;
    item_queue.push_back(it);
    if (has || eom)
      real_items++;
  endfunction

  // random message of len bytes with a few empty items sprinkled in; the end
  // comes on the last byte or on a separate empty item
  function automatic void add_message(input int len, input bit close_empty,
                                      input bit drain);
    bit first;
    first = drain;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        add_item(8'($urandom), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      add_item(8'($urandom), 1'b1, (i == len - 1) && !close_empty, first);
      first = 1'b0;
    end
    if (len == 0 || close_empty)
      add_item(8'($urandom), 1'b0, 1'b1, first);
  endfunction

  // idle odds in percent: sender 26 / sink 63, then swapped, then none
  function automatic int idle_pct(input bit sink_side);
    int phase;
    phase = (items_total > 0) ? items_taken * 3 / items_total : 0;
    case (phase)
      0: return sink_side ? 63 : 26;
      1: return sink_side ? 26 : 63;
      default: return 0;
    endcase
  endfunction

  function automatic void flag_error(input string what, input digest_entry_t want,
                                     input digest_entry_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ERROR %s: expected word %h idx %0d last %0b, got word %h idx %0d last %0b",
               $time, what, want.digest_word, want.word_index, want.last_word,
               got.digest_word, got.word_index, got.last_word);
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // driver: offers items from item_queue, feeds the model on each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_stream.valid <= 1'b0;
      items_taken     <= 0;
    end else begin
      offer = in_stream.valid;
      if (in_stream.valid && in_stream.ready) begin
        hash_item(live_item);
        items_taken <= items_taken + 1;
        offer = 1'b0;
      end
      // words_seen is an NBA from the monitor, so the drain check sees the
      // count from before this edge regardless of process order
      if (!offer && item_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        if (!item_queue[0].drain || words_expected == words_seen) begin
          live_item = item_queue.pop_front();
          in_stream.data_byte      <= live_item.data_byte;
          in_stream.has_byte       <= live_item.has_byte;
          in_stream.end_of_message <= live_item.end_of_message;
          offer = 1'b1;
        end
      end
      in_stream.valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks digest words, drives a random ready with one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_entry_t got;
    digest_entry_t want;
    if (rst) begin
      out_stream.ready <= 1'b0;
      words_seen       <= 0;
      hold_left        <= 0;
      hold_done        <= 1'b0;
    end else begin
      if (out_stream.valid && out_stream.ready) begin
        got.digest_word = out_stream.digest_word;
        got.word_index  = out_stream.word_index;
        got.last_word   = out_stream.last_word;
        words_seen <= words_seen + 1;
        if (digest_due.size() == 0) begin
          flag_error("digest word with none pending", '0, got);
        end else begin
          want = digest_due.pop_front();
          if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
              got.last_word !== want.last_word)
            flag_error("digest word mismatch", want, got);
        end
      end
      // the long hold-off backs up the digest output; the engine keeps its
      // input closed until the last word leaves, so the driver sits stalled
      if (hold_left > 0) begin
        hold_left        <= hold_left - 1;
        out_stream.ready <= 1'b0;
      end else if (!hold_done && out_stream.valid && words_seen >= 10) begin
        hold_left        <= HOLD_CYCLES;
        hold_done        <= 1'b1;
        out_stream.ready <= 1'b0;
      end else begin
        out_stream.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long with no transfer on either stream
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_stream.valid && in_stream.ready) ||
                 (out_stream.valid && out_stream.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ERROR no transfer for %0d cycles", $time, quiet_cycles);
      $display("** sha1_hash: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int base_items;
    int msgs;
    int len;

    rst                      = 1'b1;
    in_stream.valid          = 1'b0;
    in_stream.data_byte      = 8'h00;
    in_stream.has_byte       = 1'b0;
    in_stream.end_of_message = 1'b0;
    out_stream.ready         = 1'b0;
    reload_chain();

    // directed part
    add_item(8'hFF, 1'b0, 1'b1, 1'b0);   // empty message: end with no byte
    add_item(8'h61, 1'b1, 1'b0, 1'b0);   // "abc", end rides on the last byte
    add_item(8'h62, 1'b1, 1'b0, 1'b0);
    add_item(8'h63, 1'b1, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0, 1'b0);   // empty item, ignored
    add_item(8'h00, 1'b1, 1'b1, 1'b0);   // single low byte with end
    add_item(8'hFF, 1'b1, 1'b1, 1'b0);   // single high byte with end
    add_item(8'h80, 1'b1, 1'b0, 1'b0);
    add_item(8'hA5, 1'b0, 1'b0, 1'b0);   // ignored byte between real ones
    add_item(8'h7F, 1'b1, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0, 1'b0);
    add_item(8'h01, 1'b1, 1'b0, 1'b0);
    add_item(8'hFE, 1'b1, 1'b0, 1'b0);
    add_item(8'h3C, 1'b0, 1'b1, 1'b0);   // end on an empty item after bytes
    add_item(8'hC3, 1'b0, 1'b1, 1'b0);   // back-to-back empty message

    // random part: first a message that needs two pad blocks (or a full
    // block then padding), then one that fills exactly to the length field,
    // then one that waits for every pending digest
    base_items = real_items;
    msgs       = 0;
    while (real_items < base_items + RANDOM_ITEMS || msgs < RANDOM_MSGS) begin
      if (msgs == 0)
        len = $urandom_range(56, 64);
      else if (msgs == 1)
        len = 55;
      else if ($urandom_range(0, 9) == 0)
        len = $urandom_range(40, 70);
      else
        len = $urandom_range(0, 16);
      // message three starts only once every pending digest has drained
      add_message(len, $urandom_range(0, 3) == 0, msgs == 2);
      msgs++;
    end
    // trailing bytes with no end: a started message never closed
    for (int i = 0; i < 5; i++)
      add_item(8'($urandom), 1'b1, 1'b0, 1'b0);
    items_total = item_queue.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < items_total)
      @(negedge clk);
    while (words_seen < words_expected)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (digest_due.size() > 0) begin
      $display("%0t ERROR %0d digest words never arrived", $time, digest_due.size());
      mismatches += digest_due.size();
    end

    if (mismatches == 0)
      $display("** sha1_hash: PASSED **");
    else
      $display("** sha1_hash: FAILED **");
    $finish;
  end

endmodule

// ----- sha1_hash.f -----
+incdir+sv
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_sched.sv
sv/sha_round.sv
sv/sha1_hash.sv
test/testbench.sv
